[design/cuv_pkg.sv]
`timescale 1ns / 1ps
// Types, constants and the arctangent table shared by the cylindrical UV generator.
package cuv_pkg;

    localparam int COORD_W = 16;
    localparam int ACC_W   = 40;
    localparam int ANG_W   = 27;
    localparam int TAB_W   = 22;
    localparam int SCALE_SH = 20;

    localparam logic [15:0] U_QUARTER       = 16'd8192;
    localparam logic [15:0] U_HALF          = 16'd16384;
    localparam logic [15:0] U_THREE_QUARTER = 16'd24576;
    localparam logic [15:0] U_ONE           = 16'd32768;
    localparam logic [15:0] U_MAX           = 16'd32767;

    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 27'sd4194304;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 27'sd8388608;
    localparam logic signed [ANG_W-1:0] ROUND_HALF   = 27'sd256;
    localparam int ROUND_SH = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } cuv_state_t;

    // atan(2^-i) / (2*pi) in units of 2^-24 turn.
    function automatic logic [TAB_W-1:0] atan_turn(input logic [4:0] idx);
        logic [TAB_W-1:0] val;
        unique case (idx)
            5'd0:  val = 22'd2097152;
            5'd1:  val = 22'd1238021;
            5'd2:  val = 22'd654136;
            5'd3:  val = 22'd332050;
            5'd4:  val = 22'd166669;
            5'd5:  val = 22'd83416;
            5'd6:  val = 22'd41718;
            5'd7:  val = 22'd20860;
            5'd8:  val = 22'd10430;
            5'd9:  val = 22'd5215;
            5'd10: val = 22'd2608;
            5'd11: val = 22'd1304;
            5'd12: val = 22'd652;
            5'd13: val = 22'd326;
            5'd14: val = 22'd163;
            5'd15: val = 22'd81;
            5'd16: val = 22'd41;
            5'd17: val = 22'd20;
            5'd18: val = 22'd10;
            5'd19: val = 22'd5;
            5'd20: val = 22'd3;
            5'd21: val = 22'd1;
            5'd22: val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

[design/cuv_intf.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for vertex input beats and UV result beats.
interface cuv_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] z_pos;

    modport source (output valid, output x_pos, output y_pos, output z_pos, input ready);
    modport sink (input valid, input x_pos, input y_pos, input z_pos, output ready);
endinterface

interface cuv_uv_if;
    logic               valid;
    logic               ready;
    logic        [15:0] u_coord;
    logic signed [15:0] v_coord;
    logic               face_last;

    modport source (output valid, output u_coord, output v_coord, output face_last, input ready);
    modport sink (input valid, input u_coord, input v_coord, input face_last, output ready);
endinterface

[design/cylindrical_uv_generator.sv]
`timescale 1ns / 1ps
// Cylindrical texture mapping of triangle vertices with an iterative vectoring CORDIC.
//
//   channel  direction  beat payload                         handshake
//   vtx      in         x_pos, y_pos, z_pos (signed Q3.12)  valid / ready
//   uv       out        u_coord (Q1.15), v_coord, face_last  valid / ready
//
// Each vertex is loaded in ST_IDLE, takes one CORDIC iteration per ST_CALC step of the
// shared add/shift unit, and has u finished in ST_DONE.
// Three result beats leave from an output buffer after the third vertex of a face,
// while the next vertex is already being computed.
// Reset clears the sequencer, the fill count and the output buffer state.
// A stalled output only holds the block when a further face is finished.
module cylindrical_uv_generator #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    cuv_vtx_if.sink     vtx,
    cuv_uv_if.source    uv
);
    import cuv_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int IDX_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    cuv_state_t state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [1:0] fill_reg, fill_next;
    logic out_busy_reg, out_busy_next;
    logic [1:0] out_idx_reg, out_idx_next;

    logic signed [ACC_W-1:0] a_reg, a_next;
    logic signed [ACC_W-1:0] b_reg, b_next;
    logic signed [ANG_W-1:0] ang_reg, ang_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic signed [COORD_W-1:0] z_reg, z_next;

    logic [15:0] slot_u_reg [2];
    logic [15:0] slot_v_reg [2];
    logic [15:0] out_u_reg [3];
    logic [15:0] out_v_reg [3];

    logic signed [COORD_W:0] z_abs;
    logic signed [COORD_W:0] x_adj;
    logic signed [ACC_W-1:0] a_shift;
    logic signed [ACC_W-1:0] b_shift;
    logic signed [ANG_W-1:0] atan_val;
    logic signed [ANG_W-1:0] turn;
    logic signed [ANG_W-1:0] rounded;
    logic [15:0] u_val;
    logic [15:0] us [3];
    logic front;
    logic endp;
    logic slot_wr;
    logic out_load;

    always_comb
    begin
        z_abs = vtx.z_pos[COORD_W-1] ? -(COORD_W+1)'(vtx.z_pos) : (COORD_W+1)'(vtx.z_pos);
        x_adj = vtx.z_pos[COORD_W-1] ? -(COORD_W+1)'(vtx.x_pos) : (COORD_W+1)'(vtx.x_pos);
        a_shift = a_reg >>> step_reg;
        b_shift = b_reg >>> step_reg;
        atan_val = ANG_W'(atan_turn(5'(step_reg)));

        turn = ang_reg + QUARTER_TURN;
        if (z_reg > 0)
        begin
            turn = turn + HALF_TURN;
        end
        rounded = (turn + ROUND_HALF) >>> ROUND_SH;
        if (z_reg == 0)
        begin
            u_val = x_reg[COORD_W-1] ? U_HALF : U_ONE;
        end
        else if (x_reg == 0)
        begin
            u_val = z_reg[COORD_W-1] ? U_QUARTER : U_THREE_QUARTER;
        end
        else if (turn[ANG_W-1])
        begin
            u_val = '0;
        end
        else if (rounded > ANG_W'(U_MAX))
        begin
            u_val = U_MAX;
        end
        else
        begin
            u_val = rounded[15:0];
        end

        us[0] = slot_u_reg[0];
        us[1] = slot_u_reg[1];
        us[2] = u_val;
        front = (us[0] < U_HALF) || (us[1] < U_HALF) || (us[2] < U_HALF);
        endp = (us[0] == U_ONE) || (us[1] == U_ONE) || (us[2] == U_ONE);
        for (int k = 0; k < 3; k++)
        begin
            if (front && endp && us[k] == U_ONE)
            begin
                us[k] = '0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        fill_next = fill_reg;
        out_busy_next = out_busy_reg;
        out_idx_next = out_idx_reg;
        a_next = a_reg;
        b_next = b_reg;
        ang_next = ang_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        slot_wr = 1'b0;
        out_load = 1'b0;
        vtx.ready = 1'b0;

        if (uv.valid && uv.ready)
        begin
            if (out_idx_reg == 2'd2)
            begin
                out_busy_next = 1'b0;
                out_idx_next = '0;
            end
            else
            begin
                out_idx_next = out_idx_reg + 2'd1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                vtx.ready = 1'b1;
                if (vtx.valid)
                begin
                    x_next = vtx.x_pos;
                    y_next = vtx.y_pos;
                    z_next = vtx.z_pos;
                    a_next = ACC_W'(z_abs) <<< SCALE_SH;
                    b_next = ACC_W'(x_adj) <<< SCALE_SH;
                    ang_next = '0;
                    step_next = '0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (!b_reg[ACC_W-1])
                begin
                    a_next = a_reg + b_shift;
                    b_next = b_reg - a_shift;
                    ang_next = ang_reg + atan_val;
                end
                else
                begin
                    a_next = a_reg - b_shift;
                    b_next = b_reg + a_shift;
                    ang_next = ang_reg - atan_val;
                end
                if (step_reg == IDX_W'(STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (fill_reg != 2'd2)
                begin
                    slot_wr = 1'b1;
                    fill_next = fill_reg + 2'd1;
                    state_next = ST_IDLE;
                end
                else if (!out_busy_reg)
                begin
                    out_load = 1'b1;
                    out_busy_next = 1'b1;
                    out_idx_next = '0;
                    fill_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            fill_reg <= '0;
            out_busy_reg <= 1'b0;
            out_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            fill_reg <= fill_next;
            out_busy_reg <= out_busy_next;
            out_idx_reg <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        ang_reg <= ang_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (slot_wr)
        begin
            slot_u_reg[fill_reg[0]] <= u_val;
            slot_v_reg[fill_reg[0]] <= y_reg;
        end
        if (out_load)
        begin
            out_u_reg[0] <= us[0];
            out_u_reg[1] <= us[1];
            out_u_reg[2] <= us[2];
            out_v_reg[0] <= slot_v_reg[0];
            out_v_reg[1] <= slot_v_reg[1];
            out_v_reg[2] <= y_reg;
        end
    end

    assign uv.valid = out_busy_reg;
    assign uv.u_coord = out_u_reg[out_idx_reg];
    assign uv.v_coord = out_v_reg[out_idx_reg];
    assign uv.face_last = (out_idx_reg == 2'd2);

endmodule

[bench/tb_cylindrical_uv_generator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cylindrical_uv_generator against a CORDIC predictor.
module tb_cylindrical_uv_generator;
    import cuv_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int LOOPS        = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4 * (CORDIC_STEPS + 2);
    localparam int RANDOM_FACES = 62;

    localparam longint ATAN_TURN [24] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vertex_t;

    typedef struct packed {
        logic        [15:0] u;
        logic signed [15:0] v;
        logic               face_last;
    } uv_beat_t;

    logic clk;
    logic rst_n = 1'b1;

    cuv_vtx_if vtx_bus ();
    cuv_uv_if  uv_bus ();

    cylindrical_uv_generator #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx_bus),
        .uv    (uv_bus)
    );

    vertex_t            vertex_queue [$];
    uv_beat_t           uv_expect [$];
    logic        [15:0] slot_u [2];
    logic signed [15:0] slot_v [2];
    int                 face_fill = 0;
    int                 mismatch_count = 0;
    int unsigned        cycle_cnt = 0;
    logic               steady;

    assign steady = (cycle_cnt >= 1500) && (cycle_cnt < 2700);

    function automatic logic [15:0] cylinder_u(logic signed [15:0] x, logic signed [15:0] z);
        longint a;
        longint b;
        longint na;
        longint nb;
        longint ang;
        longint t;
        if (z == 0)
        begin
            return (x < 0) ? U_HALF : U_ONE;
        end
        if (x == 0)
        begin
            return (z < 0) ? U_QUARTER : U_THREE_QUARTER;
        end
        a = longint'(z);
        b = longint'(x);
        if (z < 0)
        begin
            a = -a;
            b = -b;
        end
        a = a * 1048576;
        b = b * 1048576;
        ang = 0;
        for (int i = 0; i < LOOPS; i++)
        begin
            if (b >= 0)
            begin
                na = a + (b >>> i);
                nb = b - (a >>> i);
                ang += ATAN_TURN[i];
            end
            else
            begin
                na = a - (b >>> i);
                nb = b + (a >>> i);
                ang -= ATAN_TURN[i];
            end
            a = na;
            b = nb;
        end
        t = ang + longint'(QUARTER_TURN);
        if (z > 0)
        begin
            t += longint'(HALF_TURN);
        end
        if (t < 0)
        begin
            t = 0;
        end
        t = (t + longint'(ROUND_HALF)) >>> ROUND_SH;
        if (t > longint'(U_MAX))
        begin
            t = longint'(U_MAX);
        end
        return t[15:0];
    endfunction

    task automatic map_vertex(vertex_t p);
        logic        [15:0] us [3];
        logic signed [15:0] vs [3];
        logic        [15:0] u;
        logic               front;
        logic               seam;
        uv_beat_t           beat;
        u = cylinder_u(p.x, p.z);
        if (face_fill < 2)
        begin
            slot_u[face_fill] = u;
            slot_v[face_fill] = p.y;
            face_fill++;
        end
        else
        begin
            us[0] = slot_u[0];
            us[1] = slot_u[1];
            us[2] = u;
            vs[0] = slot_v[0];
            vs[1] = slot_v[1];
            vs[2] = p.y;
            front = 1'b0;
            seam  = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                if (us[k] < U_HALF)
                    front = 1'b1;
                if (us[k] == U_ONE)
                    seam = 1'b1;
            end
            for (int k = 0; k < 3; k++)
            begin
                beat.u         = (front && seam && us[k] == U_ONE) ? 16'd0 : us[k];
                beat.v         = vs[k];
                beat.face_last = (k == 2);
                uv_expect = {uv_expect, beat};
            end
            face_fill = 0;
        end
    endtask

    task automatic add_vertex(int x, int y, int z);
        vertex_t p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.z = 16'(z);
        vertex_queue = {vertex_queue, p};
    endtask

    function automatic logic [15:0] pick_coord();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(0, 9))
            0: r = r[0] ? 16'h7fff : 16'h8000;
            1: r = 16'($urandom_range(0, 128)) - 16'd64;
            2: r = 16'h0000;
            default: ;
        endcase
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        vertex_t nxt;
        logic    give;
        if (!rst_n)
        begin
            vtx_bus.valid <= 1'b0;
            vtx_bus.x_pos <= '0;
            vtx_bus.y_pos <= '0;
            vtx_bus.z_pos <= '0;
        end
        else
        begin
            if (vtx_bus.valid && vtx_bus.ready)
            begin
                nxt.x = vtx_bus.x_pos;
                nxt.y = vtx_bus.y_pos;
                nxt.z = vtx_bus.z_pos;
                map_vertex(nxt);
            end
            if (!vtx_bus.valid || vtx_bus.ready)
            begin
                give = (vertex_queue.size() != 0) && (steady || $urandom_range(0, 99) >= 25);
                if (give)
                begin
                    nxt = vertex_queue.pop_front();
                    vtx_bus.x_pos <= nxt.x;
                    vtx_bus.y_pos <= nxt.y;
                    vtx_bus.z_pos <= nxt.z;
                end
                vtx_bus.valid <= give;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        uv_beat_t want;
        if (!rst_n)
        begin
            uv_bus.ready <= 1'b0;
        end
        else
        begin
            if (uv_bus.valid && uv_bus.ready)
            begin
                if (uv_expect.size() == 0)
                begin
                    $error("unexpected beat: u_coord %0d, v_coord %0d, face_last %0b",
                           uv_bus.u_coord, uv_bus.v_coord, uv_bus.face_last);
                    mismatch_count++;
                end
                else
                begin
                    want = uv_expect.pop_front();
                    if (uv_bus.u_coord !== want.u)
                    begin
                        $error("u_coord: expected %0d, actual %0d", want.u, uv_bus.u_coord);
                        mismatch_count++;
                    end
                    if (uv_bus.v_coord !== want.v)
                    begin
                        $error("v_coord: expected %0d, actual %0d", want.v, uv_bus.v_coord);
                        mismatch_count++;
                    end
                    if (uv_bus.face_last !== want.face_last)
                    begin
                        $error("face_last: expected %0b, actual %0b",
                               want.face_last, uv_bus.face_last);
                        mismatch_count++;
                    end
                end
            end
            uv_bus.ready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin
        vertex_t p;
        int      spot;
        logic    wrap;
        int      quiet;
        logic    timed_out;

        rst_n <= 1'b0;

        // Seam faces: a u of 1.0 with and without a u below one half.
        add_vertex(0, 32767, 0);
        add_vertex(-32768, -32768, 0);
        add_vertex(0, 0, -1);
        add_vertex(0, 21845, 32767);
        add_vertex(32767, -21846, 0);
        add_vertex(-1, 1, 0);
        // Coordinate extremes through the CORDIC.
        add_vertex(32767, 12345, 32767);
        add_vertex(-32768, -12346, -32768);
        add_vertex(32767, 255, -32768);
        add_vertex(-32768, -256, 32767);
        add_vertex(1, 4096, -32768);
        add_vertex(-1, -4097, 32767);
        // Angles near a full turn and near zero, for saturation and the low clamp.
        add_vertex(32767, 1, 1);
        add_vertex(32767, -2, -1);
        add_vertex(-32768, 3, -1);
        add_vertex(-32768, 16384, 1);
        add_vertex(1, -16385, 1);
        add_vertex(-1, 100, -1);
        add_vertex(0, -100, 0);
        add_vertex(32767, 7, -1);
        add_vertex(100, -7, -200);
        add_vertex(0, 1000, 0);
        add_vertex(5, -1000, 0);
        add_vertex(32767, 0, 0);

        for (int f = 0; f < RANDOM_FACES; f++)
        begin
            wrap = ($urandom_range(0, 4) == 0);
            spot = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
            begin
                p.x = pick_coord();
                p.y = 16'($urandom);
                p.z = pick_coord();
                if (wrap && k == spot)
                begin
                    p.z = 16'sd0;
                    p.x = 16'($urandom_range(0, 32767));
                end
                vertex_queue = {vertex_queue, p};
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        quiet = 0;
        timed_out = 1'b0;
        while (vertex_queue.size() != 0 || vtx_bus.valid || uv_expect.size() != 0)
        begin
            @(negedge clk);
            if ((vtx_bus.valid && vtx_bus.ready) || (uv_bus.valid && uv_bus.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                timed_out = 1'b1;
                break;
            end
        end

        if (timed_out)
        begin
            $display("DONE: errors detected");
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (mismatch_count == 0 && uv_expect.size() == 0)
                $display("DONE: 0 errors");
            else
                $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
